FILE: design/sorted_seqnum_insert_table_assert.svh
// Assertion macros for the sorted sequence-number table.
// Needs clk and arst_n in the scope of the including module.
`ifndef SORTED_SEQNUM_INSERT_TABLE_ASSERT_SVH
`define SORTED_SEQNUM_INSERT_TABLE_ASSERT_SVH

// same-cycle implication
`define SSIT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSIT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/ssit_pkg.sv
// Shared types and constants of the sorted sequence-number table.
// Used by ssit_store and sorted_seqnum_insert_table; depends on nothing.
package ssit_pkg;

	localparam int DEPTH      = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int KEY_W      = 63;
	localparam int HDL_W      = 16;
	localparam int CMD_W      = 2;
	localparam int STATUS_W   = 2;
	localparam int SLOT_W     = 6;
	localparam int IN_DATA_W  = ((KEY_W + HDL_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * SLOT_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam int CMD_CLEAR_BIT = 1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2,
		ST_CLEARED   = 2'd3
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [HDL_W-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} store_wr_t;

endpackage

FILE: design/sorted_seqnum_insert_table.sv
// Top level of the sorted sequence-number table: sequencer and shared key
// comparator around the entry memory. Depends on ssit_pkg, ssit_store and
// sorted_seqnum_insert_table_assert.svh.
//
// Usage: one command item on s_axis (cmd in tuser; seq_num and
// payload_handle in tdata) gives exactly one result item on m_axis (status
// in tuser; slot and entry_count in tdata). One item is worked on at a
// time; s_axis_tready is high only while the sequencer is idle.
// Steps: clear, full table, append and insert into an empty table go
//   straight to the result; an ordered insert checks the head entry for a
//   duplicate, then the tail entry for an append, else scans up from slot 0
//   to the first equal or larger key; on a larger key it moves the entries
//   from the tail down to that slot up by one and places the new entry there.
// The sequencer uses the single comparator and the one read and one
// write port of the entry memory: each scan or move step is one read.
// The result waits in an output register; the finishing step holds while
// that register is still full and unclaimed, so a stalled receiver stalls
// the sequencer but loses nothing.
// Reset empties the table (entry count zero) and drops any pending result;
// memory contents are not cleared and never used before written.
module sorted_seqnum_insert_table (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// seq_num [62:0], payload_handle [78:63], zero [79]
	input  logic [ssit_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// cmd [1:0]
	input  logic [ssit_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// slot [5:0], entry_count [11:6], zero [15:12]
	output logic [ssit_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// status [1:0]
	output logic [ssit_pkg::STATUS_W-1:0]     m_axis_tuser
);
	import ssit_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_HEAD, S_TAIL, S_SCAN, S_SHIFT, S_PLACE, S_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] pos_q;
	logic [KEY_W-1:0] key_q;
	logic [HDL_W-1:0] hdl_q;
	status_t          res_status_q;
	logic [IDX_W-1:0] res_slot_q;

	store_wr_t        wr;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_entry;

	logic             accept;
	logic             full;
	logic             cmp_eq;
	logic             cmp_lt;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] count_idx;
	logic [KEY_W-1:0] in_key;
	logic [HDL_W-1:0] in_hdl;
	logic             direct_put;

	ssit_store u_store (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (rd_addr),
		.rd_data (rd_entry)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign in_key        = s_axis_tdata[KEY_W-1:0];
	assign in_hdl        = s_axis_tdata[KEY_W +: HDL_W];
	assign full          = (count_q == CNT_W'(DEPTH));
	assign last_idx      = IDX_W'(count_q - CNT_W'(1));
	assign count_idx     = count_q[IDX_W-1:0];
	assign cmp_eq        = (rd_entry.key == key_q);
	assign cmp_lt        = (key_q < rd_entry.key);
	assign direct_put    = (s_axis_tuser == CMD_APPEND) || (count_q == '0);

	always_comb begin
		rd_addr      = '0;
		wr.we        = 1'b0;
		wr.addr      = count_idx;
		wr.data.key    = key_q;
		wr.data.handle = hdl_q;
		case (state_q)
			S_IDLE: begin
				if (accept && !s_axis_tuser[CMD_CLEAR_BIT] && !full && direct_put) begin
					wr.we          = 1'b1;
					wr.data.key    = in_key;
					wr.data.handle = in_hdl;
				end
			end
			S_HEAD: begin
				rd_addr = last_idx;
			end
			S_TAIL: begin
				wr.we = !cmp_eq && !cmp_lt;
			end
			S_SCAN: begin
				if (cmp_lt) begin
					rd_addr = last_idx;
				end else begin
					rd_addr = idx_q + IDX_W'(1);
					wr.we   = !cmp_eq && (idx_q == last_idx);
				end
			end
			S_SHIFT: begin
				rd_addr = idx_q - IDX_W'(1);
				wr.we   = 1'b1;
				wr.addr = idx_q + IDX_W'(1);
				wr.data = rd_entry;
			end
			S_PLACE: begin
				wr.we   = 1'b1;
				wr.addr = pos_q;
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			count_q       <= '0;
			idx_q         <= '0;
			pos_q         <= '0;
			key_q         <= '0;
			hdl_q         <= '0;
			res_status_q  <= ST_INSERTED;
			res_slot_q    <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= '0;
		end else begin
			if (m_axis_tready && state_q != S_DONE) begin
				m_axis_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q      <= in_key;
						hdl_q      <= in_hdl;
						res_slot_q <= '0;
						state_q    <= S_DONE;
						if (s_axis_tuser[CMD_CLEAR_BIT]) begin
							count_q      <= '0;
							res_status_q <= ST_CLEARED;
						end else if (full) begin
							res_status_q <= ST_FULL;
						end else if (direct_put) begin
							count_q      <= count_q + CNT_W'(1);
							res_slot_q   <= count_idx;
							res_status_q <= ST_INSERTED;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					if (cmp_eq) begin
						res_status_q <= ST_DUPLICATE;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					if (!cmp_eq && !cmp_lt) begin
						count_q      <= count_q + CNT_W'(1);
						res_slot_q   <= count_idx;
						res_status_q <= ST_INSERTED;
						state_q      <= S_DONE;
					end else begin
						idx_q   <= '0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (cmp_eq) begin
						res_status_q <= ST_DUPLICATE;
						state_q      <= S_DONE;
					end else if (cmp_lt) begin
						pos_q   <= idx_q;
						idx_q   <= last_idx;
						state_q <= S_SHIFT;
					end else if (idx_q == last_idx) begin
						count_q      <= count_q + CNT_W'(1);
						res_slot_q   <= count_idx;
						res_status_q <= ST_INSERTED;
						state_q      <= S_DONE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SHIFT: begin
					if (idx_q == pos_q) begin
						state_q <= S_PLACE;
					end else begin
						idx_q <= idx_q - IDX_W'(1);
					end
				end
				S_PLACE: begin
					count_q      <= count_q + CNT_W'(1);
					res_slot_q   <= pos_q;
					res_status_q <= ST_INSERTED;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tuser  <= res_status_q;
						m_axis_tdata  <= OUT_DATA_W'({SLOT_W'(count_q), SLOT_W'(res_slot_q)});
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`include "sorted_seqnum_insert_table_assert.svh"

	`SSIT_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`SSIT_ASSERT_IMP(a_shift_above_pos, state_q == S_SHIFT, idx_q >= pos_q, "move below insert slot")
	`SSIT_ASSERT_NXT(a_place_counts, state_q == S_PLACE, count_q == $past(count_q) + CNT_W'(1), "place without count advance")
	`SSIT_ASSERT_IMP(a_write_in_range, wr.we, CNT_W'(wr.addr) <= count_q && !full, "write beyond fill")

endmodule

FILE: design/ssit_store.sv
// Entry memory of the sorted sequence-number table: one write port, one
// registered read port. Depends on ssit_pkg.
module ssit_store (
	input  logic                    clk,
	input  ssit_pkg::store_wr_t     wr,
	input  logic [ssit_pkg::IDX_W-1:0] rd_addr,
	output ssit_pkg::entry_t        rd_data
);
	import ssit_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
